### hw/rtl/bfa_pkg.sv
// Shared types and codes for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int FRAME_W     = 16;
	localparam int CFG_W       = 17;
	localparam int FRAME_SPACE = 65536;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [1:0]         req_t;
	typedef logic [1:0]         status_t;

	localparam req_t REQ_ALLOC = 2'd0;
	localparam req_t REQ_FREE  = 2'd1;
	localparam req_t REQ_TEST  = 2'd2;

	localparam status_t STAT_DONE    = 2'd0;
	localparam status_t STAT_SKIPPED = 2'd1;
	localparam status_t STAT_NOFRAME = 2'd2;

endpackage

### hw/rtl/bfa_bitmap_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
`timescale 1ns / 1ps

module bfa_bitmap_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/bitmap_frame_allocator.sv
// Bitmap first-fit page frame allocator: top level with request sequencer.
`timescale 1ns / 1ps

// One bit per page frame is held in a synchronous memory of WORD_BITS-wide
// words; one request is worked at a time through its single read and write port.
// Test and free read their bitmap word in S_ADDR, clear the bit (free) or
// sample it (test) in S_EXEC and pass the result on from S_DONE; skipped
// requests (unused kind, allocate on a mapped page, free of frame zero) go
// from S_IDLE straight to S_DONE. Allocate reads one bitmap word per pass
// through S_SCAN and S_SCHK, starting at the lowest word that may still hold
// a clear frame (a hint register tracks it), so a fresh or lightly fragmented
// map allocates after a single word read; a search that runs into the frame
// limit at a word boundary ends in an S_SCAN that reads nothing. The
// allocate result reaches the output register in the same cycle as the block
// returns to S_IDLE. A stalled output register holds the block in its last
// state until the result moves on.
// After reset the block clears the memory, one word a cycle, across all
// ceil(MAX_FRAMES / WORD_BITS) words (2048 with the defaults) and holds
// in_stall high until done; configuration writes are taken at any time.
// A new request is accepted while the previous result still waits in the
// output register.
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = 65536,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [15:0]               current_frame,
	input  logic                      kernel_page,
	input  logic                      page_writable,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [15:0]               frame_number,
	output logic                      present_bit,
	output logic                      rw_bit,
	output logic                      user_bit,
	output logic [1:0]                status,
	output logic                      frame_used,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bfa_pkg::CFG_W-1:0] cfg_data
);

	localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int HW        = $clog2(NUM_WORDS + 1);
	localparam int BW        = $clog2(WORD_BITS);
	localparam int FW_X      = $clog2(NUM_WORDS * WORD_BITS + 1);
	localparam int CW        = (FW_X > bfa_pkg::CFG_W) ? FW_X : bfa_pkg::CFG_W;
	localparam int FLIM      = (MAX_FRAMES < bfa_pkg::FRAME_SPACE) ?
	                           MAX_FRAMES : bfa_pkg::FRAME_SPACE;
	// word index of a 16-bit frame by reciprocal multiply, exact for all inputs
	localparam int SH        = bfa_pkg::FRAME_W + BW;
	localparam int PW        = bfa_pkg::FRAME_W + SH;
	localparam logic [PW-1:0] RECIP = PW'(((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SCHK  = 3'd3;
	localparam logic [2:0] S_ADDR  = 3'd4;
	localparam logic [2:0] S_EXEC  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]                 state_q;
	logic [AW-1:0]              clr_q;
	logic [HW-1:0]              hint_q;
	logic [HW-1:0]              ptr_q;
	logic [bfa_pkg::CFG_W-1:0]  limit_q;

	bfa_pkg::req_t              req_q;
	bfa_pkg::frame_t            cur_q;
	bfa_pkg::frame_t            quo_q;
	logic [BW-1:0]              bit_q;
	logic                       kern_q;
	logic                       wr_q;
	logic                       in_map_q;

	bfa_pkg::frame_t            res_frame_q;
	logic                       res_present_q;
	logic                       res_rw_q;
	logic                       res_user_q;
	bfa_pkg::status_t           res_status_q;
	logic                       res_used_q;

	logic                       out_valid_q;
	bfa_pkg::frame_t            out_frame_q;
	logic                       out_present_q;
	logic                       out_rw_q;
	logic                       out_user_q;
	bfa_pkg::status_t           out_status_q;
	logic                       out_used_q;

	logic                       accept;
	logic                       out_load;
	logic [PW-1:0]              quo_prod;
	bfa_pkg::frame_t            quo_in;
	logic                       in_map_in;
	bfa_pkg::frame_t            rem_full;
	logic [CW-1:0]              ptr_base;
	logic [BW-1:0]              pe;
	logic [CW-1:0]              found;
	logic                       word_full;
	logic [WORD_BITS-1:0]       set_word;
	logic [WORD_BITS-1:0]       clr_word;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [WORD_BITS-1:0]       wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [WORD_BITS-1:0]       rd_data;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign quo_prod  = PW'(current_frame) * RECIP;
	assign quo_in    = quo_prod[PW-1:SH];
	assign in_map_in = CW'(current_frame) < CW'(MAX_FRAMES);
	assign rem_full  = cur_q - bfa_pkg::FRAME_W'(32'(quo_q) * 32'(WORD_BITS));

	assign ptr_base  = CW'(ptr_q) * CW'(WORD_BITS);
	assign word_full = &rd_data;
	assign found     = ptr_base + CW'(pe);
	assign set_word  = rd_data | (WORD_BITS'(1) << pe);
	assign clr_word  = rd_data & ~(WORD_BITS'(1) << bit_q);

	// lowest clear bit of the word just read
	always_comb begin
		pe = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (!rd_data[j]) pe = BW'(j);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = AW'(ptr_q);
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				rd_en = (ptr_base < CW'(limit_q));
			end
			S_SCHK: begin
				wr_en   = !word_full && (found < CW'(limit_q));
				wr_addr = AW'(ptr_q);
				wr_data = set_word;
			end
			S_ADDR: begin
				rd_en   = in_map_q;
				rd_addr = AW'(quo_q);
			end
			S_EXEC: begin
				wr_en   = in_map_q && (req_q == bfa_pkg::REQ_FREE);
				wr_addr = AW'(quo_q);
				wr_data = clr_word;
			end
			default: begin
			end
		endcase
	end

	bfa_bitmap_ram #(
		.DEPTH (NUM_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bfa_pkg::CFG_W'(FLIM);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= (cfg_data > bfa_pkg::CFG_W'(FLIM)) ? bfa_pkg::CFG_W'(FLIM) : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hint_q  <= '0;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req_type == bfa_pkg::REQ_ALLOC && current_frame == '0) begin
							ptr_q   <= hint_q;
							state_q <= S_SCAN;
						end else if (req_type == bfa_pkg::REQ_TEST ||
						             (req_type == bfa_pkg::REQ_FREE && current_frame != '0)) begin
							state_q <= S_ADDR;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					state_q <= rd_en ? S_SCHK : S_DONE;
				end
				S_SCHK: begin
					if (word_full) begin
						ptr_q   <= ptr_q + HW'(1);
						state_q <= S_SCAN;
					end else begin
						// words below the hint are all full
						if (wr_en) begin
							hint_q <= (&set_word) ? ptr_q + HW'(1) : ptr_q;
						end
						state_q <= S_DONE;
					end
				end
				S_ADDR: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (wr_en && HW'(quo_q) < hint_q) begin
						hint_q <= HW'(quo_q);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q         <= req_type;
			cur_q         <= current_frame;
			quo_q         <= quo_in;
			kern_q        <= kernel_page;
			wr_q          <= page_writable;
			in_map_q      <= in_map_in;
			res_frame_q   <= current_frame;
			res_present_q <= 1'b0;
			res_rw_q      <= 1'b0;
			res_user_q    <= 1'b0;
			res_status_q  <= bfa_pkg::STAT_SKIPPED;
			res_used_q    <= 1'b0;
		end
		case (state_q)
			S_SCAN: begin
				if (!rd_en) begin
					res_frame_q  <= '0;
					res_status_q <= bfa_pkg::STAT_NOFRAME;
				end
			end
			S_SCHK: begin
				if (!word_full) begin
					if (wr_en) begin
						res_frame_q   <= bfa_pkg::FRAME_W'(found);
						res_present_q <= 1'b1;
						res_rw_q      <= wr_q;
						res_user_q    <= !kern_q;
						res_status_q  <= bfa_pkg::STAT_DONE;
					end else begin
						res_frame_q  <= '0;
						res_status_q <= bfa_pkg::STAT_NOFRAME;
					end
				end
			end
			S_ADDR: begin
				bit_q <= rem_full[BW-1:0];
			end
			S_EXEC: begin
				res_status_q <= bfa_pkg::STAT_DONE;
				if (req_q == bfa_pkg::REQ_FREE) begin
					res_frame_q <= '0;
				end else begin
					res_used_q <= in_map_q && rd_data[bit_q];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_frame_q   <= res_frame_q;
			out_present_q <= res_present_q;
			out_rw_q      <= res_rw_q;
			out_user_q    <= res_user_q;
			out_status_q  <= res_status_q;
			out_used_q    <= res_used_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_number = out_frame_q;
	assign present_bit  = out_present_q;
	assign rw_bit       = out_rw_q;
	assign user_bit     = out_user_q;
	assign status       = out_status_q;
	assign frame_used   = out_used_q;

`ifndef NO_ASSERTIONS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("bitmap read and write issued in the same cycle");

	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= HW'(NUM_WORDS))
		else $error("free-word hint beyond the bitmap");

	a_noframe_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == bfa_pkg::STAT_NOFRAME |->
			out_frame_q == '0 && !out_present_q && !out_used_q)
		else $error("out-of-frames result carries a frame");

	a_present_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_present_q |-> out_status_q == bfa_pkg::STAT_DONE)
		else $error("present bit without a completed allocation");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> state_q == S_IDLE && out_valid_q)
		else $error("result load did not return to idle");
`endif

endmodule
